// ===== hw/rtl/sdaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdaf_pkg: shared definitions of the signed decimal ASCII formatter
// Widths, character codes, the queue depth and the job record that passes
// from the input front end to the digit converter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    localparam int VALUE_W      = 32;
    localparam int MIN_DIGITS_W = 4;
    localparam int CHAR_W       = 8;
    localparam int DIGIT_W      = 4;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;

    // ceil(2^35 / 10): floor(n * RECIP_10 / 2^35) equals n / 10 for any 32-bit n.
    localparam logic [VALUE_W-1:0] RECIP_10      = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT   = 35;

    typedef struct packed {
        logic                    neg;
        logic [VALUE_W-1:0]      mag;
        logic [MIN_DIGITS_W-1:0] min_digits;
    } job_t;

endpackage

// ===== hw/rtl/signed_decimal_ascii_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter: signed integer to decimal ASCII text
// Top level: input front end with a two-entry queue, then the digit
// converter and character emitter.
// ----------------------------------------------------------------------------
// Each accepted number comes out as a stream of ASCII characters, most
// significant first: '-' for a negative value, leading '0' characters up to
// min_digits, then the decimal digits of the magnitude (at least one, so zero
// prints "0"); last marks the final character. Only the low MAX_DIGITS digits
// are printed. The converter takes the number, peels one digit per cycle in
// the divide-by-ten loop, finishes the count and padding, then sends one
// character per cycle through the single output register while the receiver
// is ready. The front queue takes up to two further numbers while the
// converter is busy.
module signed_decimal_ascii_formatter #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [sdaf_pkg::VALUE_W-1:0]      value,
    input  logic        [sdaf_pkg::MIN_DIGITS_W-1:0] min_digits,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic        [sdaf_pkg::CHAR_W-1:0]       character,
    output logic                                     last
);
    import sdaf_pkg::*;

    job_t job;
    logic job_valid;
    logic job_ready;

    sdaf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .min_digits (min_digits),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    sdaf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule

// ===== hw/rtl/sdaf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdaf_front: input front end
// Accepts numbers, splits each into sign and unsigned magnitude, and holds
// them in a short queue until the converter is free.
// ----------------------------------------------------------------------------
module sdaf_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [sdaf_pkg::VALUE_W-1:0]     value,
    input  logic        [sdaf_pkg::MIN_DIGITS_W-1:0] min_digits,
    output logic                                    job_valid,
    input  logic                                    job_ready,
    output sdaf_pkg::job_t                          job
);
    import sdaf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    job_t             in_job;
    logic             push;
    logic             pop;
    logic [VALUE_W-1:0] raw;

    // The magnitude is formed unsigned so that the most negative value fits.
    assign raw               = $unsigned(value);
    assign in_job.neg        = raw[VALUE_W-1];
    assign in_job.mag        = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    assign in_job.min_digits = min_digits;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== hw/rtl/sdaf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdaf_back: digit converter and character emitter
// Peels one decimal digit per cycle off the magnitude by a reciprocal
// multiply, then sends sign, padding zeros and digits, one character a beat.
// ----------------------------------------------------------------------------
module sdaf_back #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  sdaf_pkg::job_t                  job,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sdaf_pkg::CHAR_W-1:0]     character,
    output logic                            last
);
    import sdaf_pkg::*;

    localparam int NDIG_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W  = (NDIG_W > MIN_DIGITS_W) ? NDIG_W : MIN_DIGITS_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_W-1:0]      mag_reg, mag_next;
    logic                    neg_pend_reg, neg_pend_next;
    logic [MIN_DIGITS_W-1:0] mindig_reg, mindig_next;
    logic [MIN_DIGITS_W-1:0] pad_reg, pad_next;
    logic [NDIG_W-1:0]       ndig_reg, ndig_next;
    logic [DIGIT_W-1:0]      digs_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0]      digs_next [MAX_DIGITS];
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;

    logic [2*VALUE_W-1:0]    prod;
    logic [VALUE_W-1:0]      quot;
    logic [VALUE_W-1:0]      quot10;
    logic [VALUE_W-1:0]      rem;
    logic                    conv_more;
    logic [NDIG_W-1:0]       ndig_fin;
    logic [NDIG_W-1:0]       ndig_dec;
    logic [CMP_W-1:0]        min_ext;
    logic [CMP_W-1:0]        nd_ext;
    logic [CMP_W-1:0]        pad_diff;
    logic                    emit_go;

    assign prod      = (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP_10);
    assign quot      = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign quot10    = (quot << 3) + (quot << 1);
    assign rem       = mag_reg - quot10;
    assign conv_more = (mag_reg != '0) && (ndig_reg < NDIG_W'(MAX_DIGITS));

    // Zero still prints one digit.
    assign ndig_fin  = (ndig_reg == '0) ? NDIG_W'(1) : ndig_reg;
    assign ndig_dec  = ndig_reg - 1'b1;
    assign min_ext   = CMP_W'(mindig_reg);
    assign nd_ext    = CMP_W'(ndig_fin);
    assign pad_diff  = min_ext - nd_ext;

    assign emit_go   = !out_valid_reg || out_ready;
    assign job_ready = (state_reg == S_IDLE);

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_pend_next  = neg_pend_reg;
        mindig_next    = mindig_reg;
        pad_next       = pad_reg;
        ndig_next      = ndig_reg;
        digs_next      = digs_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    mag_next      = job.mag;
                    neg_pend_next = job.neg;
                    mindig_next   = job.min_digits;
                    ndig_next     = '0;
                    state_next    = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_more)
                begin
                    digs_next[ndig_reg[IDX_W-1:0]] = rem[DIGIT_W-1:0];
                    mag_next  = quot;
                    ndig_next = ndig_reg + 1'b1;
                end
                else
                begin
                    if (ndig_reg == '0)
                    begin
                        digs_next[0] = '0;
                    end
                    ndig_next  = ndig_fin;
                    pad_next   = (min_ext > nd_ext) ? pad_diff[MIN_DIGITS_W-1:0] : '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    if (neg_pend_reg)
                    begin
                        char_next     = CHR_MINUS;
                        last_next     = 1'b0;
                        neg_pend_next = 1'b0;
                    end
                    else if (pad_reg != '0)
                    begin
                        char_next = CHR_ZERO;
                        last_next = 1'b0;
                        pad_next  = pad_reg - 1'b1;
                    end
                    else
                    begin
                        char_next = CHR_ZERO + CHAR_W'(digs_reg[ndig_dec[IDX_W-1:0]]);
                        last_next = (ndig_reg == NDIG_W'(1));
                        ndig_next = ndig_dec;
                        if (ndig_reg == NDIG_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            neg_pend_reg  <= 1'b0;
            pad_reg       <= '0;
            ndig_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_pend_reg  <= neg_pend_next;
            pad_reg       <= pad_next;
            ndig_reg      <= ndig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        mindig_reg <= mindig_next;
        digs_reg   <= digs_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    // Every digit index read while emitting must point at a filled slot.
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (ndig_reg != '0))
        else $error("sdaf_back: emitting with no digits left");

    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= NDIG_W'(MAX_DIGITS))
        else $error("sdaf_back: digit count beyond buffer");

    a_job_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> ((state_reg == S_CONV) && (ndig_reg == '0)))
        else $error("sdaf_back: taken job did not start a conversion");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((char_reg == CHR_MINUS) ||
                           ((char_reg >= CHR_ZERO) && (char_reg <= CHR_ZERO + CHAR_W'(9)))))
        else $error("sdaf_back: character outside sign and digit codes");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(char_reg) && $stable(last_reg)))
        else $error("sdaf_back: stalled character changed");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the signed decimal ASCII formatter
// A table of directed numbers (zero, both extremes, padding limits) is sent
// first, then random numbers in four idle phases. A number without typed text is
// turned into its expected characters by a local formatter, and each output beat
// is compared with the oldest expected character and its last flag.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_DIGITS       = sdaf_pkg::MAX_DIGITS_DEF;
    localparam int NUM_ROWS         = 20;
    localparam int RANDOM_PER_PHASE = 58;
    localparam int NUM_PHASES       = 4;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [sdaf_pkg::CHAR_W-1:0] character;
        logic                        last;
    } text_char_t;

    logic                                     clk;
    logic                                     rst_n;
    logic                                     in_valid;
    logic                                     in_ready;
    logic signed [sdaf_pkg::VALUE_W-1:0]      value;
    logic        [sdaf_pkg::MIN_DIGITS_W-1:0] min_digits;
    logic                                     out_valid;
    logic                                     out_ready = 1'b0;
    logic        [sdaf_pkg::CHAR_W-1:0]       character;
    logic                                     last;

    text_char_t pending_chars[$];
    int         errors         = 0;
    int         numbers_sent   = 0;
    int         negatives_sent = 0;
    int         chars_checked  = 0;
    int         longest_text   = 0;
    int         tx_idle_pct    = 0;
    int         rx_stall_pct   = 0;

    // Directed numbers. A non-empty text is the exact expected output.
    logic signed [sdaf_pkg::VALUE_W-1:0] row_value [NUM_ROWS] = '{
        32'sd0, 32'sd0, 32'sd0, 32'sh8000_0000, 32'sh8000_0000,
        32'sd2147483647, 32'sd2147483647, -32'sd1, -32'sd1, 32'sd1,
        32'sd9, 32'sd10, 32'sd42, 32'sd12345, -32'sd987654,
        32'sd1000000000, -32'sd2147483647, 32'sd99, -32'sd100, -32'sd7
    };
    logic [sdaf_pkg::MIN_DIGITS_W-1:0] row_min [NUM_ROWS] = '{
        4'd0, 4'd15, 4'd1, 4'd0, 4'd15,
        4'd0, 4'd15, 4'd0, 4'd15, 4'd0,
        4'd1, 4'd2, 4'd5, 4'd3, 4'd10,
        4'd0, 4'd11, 4'd0, 4'd4, 4'd9
    };
    string row_text [NUM_ROWS] = '{
        "0", "000000000000000", "0", "-2147483648", "-000002147483648",
        "2147483647", "000002147483647", "-1", "-000000000000001", "1",
        "", "", "", "", "",
        "", "", "", "", ""
    };

    signed_decimal_ascii_formatter #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .min_digits (min_digits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic note_error(input string what, input int expected, input int actual);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s, expected 0x%0h, got 0x%0h",
                     $realtime, what, expected, actual);
        end
    endtask

    // Expected text: sign, zero padding up to the minimum, then the digits.
    task automatic format_decimal(input logic signed [sdaf_pkg::VALUE_W-1:0] num,
                                  input logic [sdaf_pkg::MIN_DIGITS_W-1:0] min_count);
        logic                         neg;
        logic [sdaf_pkg::VALUE_W-1:0] mag;
        logic [sdaf_pkg::DIGIT_W-1:0] digits [0:19];
        int                           ndig;
        int                           pad;
        int                           k;
        int                           count;
        text_char_t                   entry;
        neg  = num[sdaf_pkg::VALUE_W-1];
        mag  = neg ? (32'd0 - num) : num;
        ndig = 0;
        while (mag != 32'd0 && ndig < MAX_DIGITS)
        begin
            digits[ndig] = sdaf_pkg::DIGIT_W'(mag % 32'd10);
            mag          = mag / 32'd10;
            ndig++;
        end
        if (ndig == 0)
        begin
            digits[0] = '0;
            ndig      = 1;
        end
        pad   = (int'(min_count) > ndig) ? int'(min_count) - ndig : 0;
        count = (neg ? 1 : 0) + pad + ndig;
        if (neg)
        begin
            entry.character = sdaf_pkg::CHR_MINUS;
            entry.last      = 1'b0;
            pending_chars.push_back(entry);
        end
        for (k = 0; k < pad; k++)
        begin
            entry.character = sdaf_pkg::CHR_ZERO;
            entry.last      = 1'b0;
            pending_chars.push_back(entry);
        end
        for (k = ndig - 1; k >= 0; k--)
        begin
            entry.character = sdaf_pkg::CHR_ZERO + digits[k];
            entry.last      = (k == 0);
            pending_chars.push_back(entry);
        end
        if (count > longest_text)
            longest_text = count;
    endtask

    // Offers one number and waits for its beat; the caller decides whether
    // valid drops afterwards.
    task automatic send_number(input logic signed [sdaf_pkg::VALUE_W-1:0] num,
                               input logic [sdaf_pkg::MIN_DIGITS_W-1:0] min_count,
                               input string typed_text);
        text_char_t entry;
        int         i;
        in_valid   <= 1'b1;
        value      <= num;
        min_digits <= min_count;
        do
            @(posedge clk);
        while (!in_ready);
        if (typed_text.len() != 0)
        begin
            for (i = 0; i < typed_text.len(); i++)
            begin
                entry.character = typed_text[i];
                entry.last      = (i == typed_text.len() - 1);
                pending_chars.push_back(entry);
            end
        end
        else
        begin
            format_decimal(num, min_count);
        end
        numbers_sent++;
        if (num < 0)
            negatives_sent++;
    endtask

    task automatic hold_off(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_text_drained();
        int n;
        n = 0;
        while (pending_chars.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Mix of full-range words, short magnitudes, decade boundaries and extremes.
    function automatic logic signed [sdaf_pkg::VALUE_W-1:0] pick_value();
        int                           sel;
        int                           k;
        longint unsigned              decade;
        logic [sdaf_pkg::VALUE_W-1:0] mag;
        sel    = $urandom_range(0, 9);
        k      = $urandom_range(1, 10);
        decade = 1;
        repeat (k) decade = decade * 10;
        case (sel)
            0, 1, 2, 3: return $urandom;
            4: mag = $urandom_range(0, 20);
            5:
            begin
                if (k == 10)
                    decade = 64'd1_000_000_000;
                mag = 32'(decade + $urandom_range(0, 2) - 1);
            end
            6:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: mag = 32'($urandom % decade);
        endcase
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    always @(posedge clk)
    begin : rx_side
        text_char_t wanted;
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                note_error("character with nothing expected", 0, character);
            end
            else
            begin
                wanted = pending_chars.pop_front();
                chars_checked++;
                if (character !== wanted.character)
                    note_error("character", wanted.character, character);
                if (last !== wanted.last)
                    note_error("last flag", wanted.last, last);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int row;
        int ph;
        int n;
        int gap;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        min_digits = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < NUM_ROWS; row++)
            send_number(row_value[row], row_min[row], row_text[row]);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // The sender holds off until the whole backlog of text is out.
            in_valid <= 1'b0;
            wait_for_text_drained();
            @(posedge clk);
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 8) : 0;
                if (gap > 0)
                    hold_off(gap);
                send_number(pick_value(), 4'($urandom_range(0, 15)), "");
            end
        end
        in_valid <= 1'b0;

        wait_for_text_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            note_error("characters never emitted", pending_chars.size(), 0);
            errors += pending_chars.size() - 1;
        end

        $display("Summary: %0d numbers sent (%0d negative), %0d characters checked,",
                 numbers_sent, negatives_sent, chars_checked);
        $display("longest text %0d characters, idle phases none/sender/receiver/both, %0d errors",
                 longest_text, errors);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sdaf_pkg.sv
hw/rtl/sdaf_front.sv
hw/rtl/sdaf_back.sv
hw/rtl/signed_decimal_ascii_formatter.sv
tb/sv/testbench.sv
